### hdl/wbd_pkg.sv
// ----------------------------------------------------------------------------
// wbd_pkg
// Shared types and constants of the windowed button debouncer.
// ----------------------------------------------------------------------------
`default_nettype none

package wbd_pkg;

    localparam int BUTTON_COUNT = 2;
    localparam int MAX_BUTTONS  = 2;
    localparam int CNT_W        = 8;
    localparam int HOLD_W       = 16;
    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_DATA_W   = 16;
    localparam int IN_DATA_W    = 8;
    localparam int OUT_DATA_W   = 8;

    localparam logic [CNT_W-1:0]  CNT_MAX            = '1;
    localparam logic [7:0]        RST_WINDOW_LENGTH  = 8'd40;
    localparam logic [7:0]        RST_RELEASE_THRESH = 8'd12;
    localparam logic [7:0]        RST_PRESS_THRESH   = 8'd24;
    localparam logic [HOLD_W-1:0] RST_HOLD_TIME_MS   = 16'd1200;

    typedef enum logic [1:0] {
        REQ_SAMPLE = 2'd0,
        REQ_TICK   = 2'd1,
        REQ_QUERY  = 2'd2
    } req_type_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_WINDOW_LENGTH = 2'd0,
        CFG_RELEASE_THRESH = 2'd1,
        CFG_PRESS_THRESH  = 2'd2,
        CFG_HOLD_TIME_MS  = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [7:0]        window_length;
        logic [7:0]        release_threshold;
        logic [7:0]        press_threshold;
        logic [HOLD_W-1:0] hold_time_ms;
    } cfg_t;

    // Per-lane command for one accepted transaction
    typedef struct packed {
        logic sample_en;
        logic tick_en;
        logic query_en;
        logic window_end;
    } lane_cmd_t;

    typedef struct packed {
        logic pressed;
        logic rise_seen;
        logic hold_active;
    } lane_res_t;

endpackage

`default_nettype wire

### hdl/windowed_button_debouncer_unit.sv
// ----------------------------------------------------------------------------
// windowed_button_debouncer_unit
// Two-button integrating debouncer with hysteresis, rise flags and hold timers.
// ----------------------------------------------------------------------------
// Input channel s_*: one transaction per request. s_tuser carries the request
// kind (sample, millisecond tick, query); s_tdata carries the raw up and down
// levels (low means pressed) and the queried button.
// Output channel m_*: exactly one result transaction per request, in order:
// rise_seen and hold_active (queries only), then both debounced states.
// Configuration: cfg_we writes cfg_data into register cfg_index at the clock
// edge (0 window length, 1 release threshold, 2 press threshold, 3 hold time).
// The result is registered into the output buffer when the request is taken.
// Throughput is one request per cycle while s_tready is high; each button lane
// updates its state when the request is taken and the window counter is shared.
// A two-entry output buffer (register plus skid stage) takes one more
// transaction while m_tready is low; s_tready drops once both entries are full
// and returns the cycle after the receiver takes one.
// Reset clears all counters, flags and timers, loads the default
// configuration (40, 12, 24, 1200) and empties the output buffer.
// ----------------------------------------------------------------------------
`default_nettype none

module windowed_button_debouncer_unit (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [wbd_pkg::IN_DATA_W-1:0]      s_tdata,  // raw_up, raw_down, query_button
    input  wire logic [1:0]                         s_tuser,  // req_type
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic [wbd_pkg::OUT_DATA_W-1:0]          m_tdata,  // rise_seen, hold_active,
                                                              // pressed_up, pressed_down
    input  wire logic                               cfg_we,
    input  wire logic [wbd_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [wbd_pkg::CFG_DATA_W-1:0]     cfg_data
);

    wbd_pkg::cfg_t      cfg_reg, cfg_next;
    logic [7:0]         win_pos_reg, win_pos_next, win_pos_inc;
    logic               in_fire;
    logic               in_ready;
    wbd_pkg::lane_cmd_t cmd;
    logic               window_end;
    logic [wbd_pkg::MAX_BUTTONS-1:0] raw_level;
    logic [wbd_pkg::MAX_BUTTONS-1:0] query_sel;
    wbd_pkg::lane_res_t [wbd_pkg::BUTTON_COUNT-1:0] lane_res;

    assign s_tready = in_ready;
    assign in_fire  = s_tvalid & in_ready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (wbd_pkg::cfg_index_t'(cfg_index))
                wbd_pkg::CFG_WINDOW_LENGTH:  cfg_next.window_length     = cfg_data[7:0];
                wbd_pkg::CFG_RELEASE_THRESH: cfg_next.release_threshold = cfg_data[7:0];
                wbd_pkg::CFG_PRESS_THRESH:   cfg_next.press_threshold   = cfg_data[7:0];
                wbd_pkg::CFG_HOLD_TIME_MS:   cfg_next.hold_time_ms      = cfg_data;
                default:                     cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        cmd = '0;
        if (in_fire)
        begin
            case (wbd_pkg::req_type_t'(s_tuser))
                wbd_pkg::REQ_SAMPLE: cmd.sample_en = 1'b1;
                wbd_pkg::REQ_TICK:   cmd.tick_en   = 1'b1;
                wbd_pkg::REQ_QUERY:  cmd.query_en  = 1'b1;
                default:             cmd = '0;
            endcase
        end
        // advance the shared window position on every sample
        win_pos_inc  = win_pos_reg + 8'd1;
        window_end   = (win_pos_inc >= cfg_reg.window_length);
        cmd.window_end = window_end;
        win_pos_next = win_pos_reg;
        if (cmd.sample_en)
            win_pos_next = window_end ? 8'd0 : win_pos_inc;

        raw_level    = s_tdata[1:0];
        query_sel[0] = ~s_tdata[2];
        query_sel[1] = s_tdata[2];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.window_length     <= wbd_pkg::RST_WINDOW_LENGTH;
            cfg_reg.release_threshold <= wbd_pkg::RST_RELEASE_THRESH;
            cfg_reg.press_threshold   <= wbd_pkg::RST_PRESS_THRESH;
            cfg_reg.hold_time_ms      <= wbd_pkg::RST_HOLD_TIME_MS;
            win_pos_reg               <= 8'd0;
        end
        else
        begin
            cfg_reg     <= cfg_next;
            win_pos_reg <= win_pos_next;
        end
    end

    for (genvar b = 0; b < wbd_pkg::BUTTON_COUNT; b++)
    begin : g_lane
        wbd_lane u_lane (
            .clk       (clk),
            .rst_n     (rst_n),
            .cfg       (cfg_reg),
            .cmd       (cmd),
            .raw_level (raw_level[b]),
            .query_sel (query_sel[b]),
            .res       (lane_res[b])
        );
    end

    wbd_merge u_merge (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (in_fire),
        .lane_res (lane_res),
        .in_ready (in_ready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire

### hdl/wbd_lane.sv
// ----------------------------------------------------------------------------
// wbd_lane
// Debounce core for one button: window count, hysteresis, rise flag, hold timer.
// ----------------------------------------------------------------------------
`default_nettype none

module wbd_lane (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire wbd_pkg::cfg_t     cfg,
    input  wire wbd_pkg::lane_cmd_t cmd,
    input  wire logic              raw_level,
    input  wire logic              query_sel,
    output wbd_pkg::lane_res_t     res
);

    logic [wbd_pkg::CNT_W-1:0]  count_reg, count_next, count_inc;
    logic                       pressed_reg, pressed_next;
    logic                       rise_reg, rise_next;
    logic [wbd_pkg::HOLD_W-1:0] hold_reg, hold_next;
    logic [wbd_pkg::HOLD_W:0]   hold_inc;
    logic                       query_hit;

    assign query_hit = cmd.query_en & query_sel;

    always_comb
    begin
        count_next   = count_reg;
        pressed_next = pressed_reg;
        rise_next    = rise_reg;
        hold_next    = hold_reg;
        // saturate at full scale
        count_inc = (!raw_level && count_reg != wbd_pkg::CNT_MAX) ?
                    count_reg + 1'b1 : count_reg;
        hold_inc  = {1'b0, hold_reg} + 1'b1;

        if (cmd.sample_en)
        begin
            count_next = count_inc;
            if (cmd.window_end)
            begin
                count_next = '0;
                if (pressed_reg)
                begin
                    if (count_inc < cfg.release_threshold)
                    begin
                        pressed_next = 1'b0;
                        rise_next    = 1'b0;
                    end
                end
                else if (count_inc > cfg.press_threshold)
                begin
                    pressed_next = 1'b1;
                    rise_next    = 1'b1;
                end
            end
        end

        if (cmd.tick_en)
        begin
            if (pressed_reg)
            begin
                if (hold_inc > {1'b0, cfg.hold_time_ms})
                    hold_next = cfg.hold_time_ms;
                else
                    hold_next = hold_inc[wbd_pkg::HOLD_W-1:0];
            end
            else
            begin
                hold_next = '0;
            end
        end

        if (query_hit)
            rise_next = 1'b0;
    end

    always_comb
    begin
        res.pressed     = pressed_next;
        res.rise_seen   = query_hit & rise_reg;
        res.hold_active = query_hit & pressed_reg & (hold_reg >= cfg.hold_time_ms);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            pressed_reg <= 1'b0;
            rise_reg    <= 1'b0;
            hold_reg    <= '0;
        end
        else
        begin
            count_reg   <= count_next;
            pressed_reg <= pressed_next;
            rise_reg    <= rise_next;
            hold_reg    <= hold_next;
        end
    end

endmodule

`default_nettype wire

### hdl/wbd_merge.sv
// ----------------------------------------------------------------------------
// wbd_merge
// Combine lane results into one result word and buffer it with a skid stage.
// ----------------------------------------------------------------------------
`default_nettype none

module wbd_merge (
    input  wire logic                                       clk,
    input  wire logic                                       rst_n,
    input  wire logic                                       in_fire,
    input  wire wbd_pkg::lane_res_t [wbd_pkg::BUTTON_COUNT-1:0] lane_res,
    output logic                                            in_ready,
    output logic                                            m_tvalid,
    input  wire logic                                       m_tready,
    output logic [wbd_pkg::OUT_DATA_W-1:0]                  m_tdata
);

    logic [wbd_pkg::MAX_BUTTONS-1:0]  pressed_pad;
    logic                             rise_any, hold_any;
    logic [wbd_pkg::OUT_DATA_W-1:0]   result;

    logic                             out_valid_reg, out_valid_next;
    logic [wbd_pkg::OUT_DATA_W-1:0]   out_data_reg, out_data_next;
    logic                             skid_valid_reg, skid_valid_next;
    logic [wbd_pkg::OUT_DATA_W-1:0]   skid_data_reg, skid_data_next;
    logic                             pop;

    // only the queried lane drives its query flags, so an OR merges them
    always_comb
    begin
        pressed_pad = '0;
        rise_any    = 1'b0;
        hold_any    = 1'b0;
        for (int i = 0; i < wbd_pkg::BUTTON_COUNT; i++)
        begin
            pressed_pad[i] = lane_res[i].pressed;
            rise_any       = rise_any | lane_res[i].rise_seen;
            hold_any       = hold_any | lane_res[i].hold_active;
        end
        result = {{(wbd_pkg::OUT_DATA_W-4){1'b0}}, pressed_pad[1], pressed_pad[0],
                  hold_any, rise_any};
    end

    assign pop      = out_valid_reg & m_tready;
    assign in_ready = ~skid_valid_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (pop)
        begin
            if (skid_valid_reg)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = in_fire;
                out_data_next  = result;
            end
        end
        else if (in_fire)
        begin
            if (!out_valid_reg)
            begin
                out_valid_next = 1'b1;
                out_data_next  = result;
            end
            else
            begin
                // hold the new result behind the stalled one
                skid_valid_next = 1'b1;
                skid_data_next  = result;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

endmodule

`default_nettype wire
